// ===== src/lsts_pkg.sv =====
// Package: shared constants and types for the least-slack task scheduler.
package lsts_pkg;
  localparam int TASKS_DEF = 8;
  localparam logic [7:0] SLACK_CEIL = 8'd255;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // One task table entry; remaining lives here too so one RAM holds it all.
  typedef struct packed {
    logic [7:0] comp;
    logic [7:0] period;
    logic [7:0] deadline;
    logic [7:0] remaining;
    logic [7:0] slack;
    logic       enabled;
  } task_entry_t;

  localparam int ENTRY_W = $bits(task_entry_t);
endpackage

// ===== src/least_slack_task_scheduler_unit.sv =====
// Least-slack-first picker over a RAM-held table of periodic tasks.
// Load item: one RAM write, result valid the cycle after accept.
// Tick item: per evaluated task one RAM read, a sequential modulo and a write back;
//   a task that is not ready is skipped without a RAM read.
// One item at a time; result held in an output register while the next waits.
// Reset: a clearing pass writes a reset entry to each of the TASKS slots; no item is taken.
module least_slack_task_scheduler_unit
  import lsts_pkg::*;
#(
  parameter int TASKS = TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [2:0]  in_slot,
  input  logic [7:0]  in_comp_time,
  input  logic [7:0]  in_period_len,
  input  logic [7:0]  in_due_time,
  input  logic        in_enable_bit,
  input  logic [7:0]  in_ready_mask,
  input  logic [15:0] in_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_pick_valid,
  output logic [2:0]  out_pick_index,
  output logic [7:0]  out_pick_slack,
  output logic [7:0]  out_miss_flags
);
  localparam int AW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int RD = (TASKS > 1) ? TASKS : 2;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_WAIT, S_MOD, S_CALC, S_FIX, S_DONE
  } state_t;

  state_t      state_r;
  logic [AW:0] idx_r;
  logic [7:0]  ready_r, miss_r;
  logic [15:0] nowm1_r;
  logic [7:0]  best_r;
  logic [AW-1:0] win_r;
  logic        found_r;
  task_entry_t ent_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  task_entry_t   wr_data, rd_data;
  logic [ENTRY_W-1:0] rd_raw;
  logic          mod_start, mod_done;
  logic [7:0]    mod_rem;

  lsts_ram #(.WIDTH(ENTRY_W), .DEPTH(RD)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_raw)
  );
  assign rd_data = task_entry_t'(rd_raw);

  // The divisor is captured on start, while the fresh entry sits on the read port.
  lsts_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(nowm1_r),
    .divisor(rd_data.period), .done(mod_done), .rem(mod_rem)
  );

  // Per-task evaluation, done on the entry with rel from the modulo unit.
  task_entry_t upd;
  logic        cand, is_miss;
  logic [9:0]  s_val;
  always_comb begin
    upd = ent_r;
    if (mod_rem == 8'd0) begin
      upd.remaining = ent_r.comp;
      upd.slack     = ent_r.deadline - ent_r.comp;
    end
    s_val   = {2'b00, upd.deadline} - {2'b00, upd.remaining} - {2'b00, mod_rem};
    cand    = 1'b0;
    is_miss = 1'b0;
    if (!(upd.remaining == 8'd0 && mod_rem != 8'd0)) begin
      if (s_val[9]) begin
        is_miss = 1'b1;
      end else begin
        upd.slack = s_val[7:0];
        cand = (s_val[7:0] < best_r);
      end
    end
  end

  logic in_acc;
  logic task_on;
  logic out_set;
  assign in_stall = (state_r != S_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign task_on  = (idx_r[AW-1:0] < 8) && ready_r[idx_r[AW-1:0] & 3'(7)];
  assign mod_start = (state_r == S_WAIT) && rd_data.enabled;
  assign out_set  = ((state_r == S_IDLE) && in_acc && (in_mode == MODE_LOAD)) ||
                    (state_r == S_FIX);

  // Memory port selection by state.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r[AW-1:0];
    wr_data = upd;
    rd_addr = idx_r[AW-1:0];
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '{comp: 8'd0, period: 8'd1, deadline: 8'd0, remaining: 8'd0,
                    slack: 8'd0, enabled: 1'b0};
      end
      S_IDLE: begin
        wr_en   = in_acc && (in_mode == MODE_LOAD) && (32'(in_slot) < TASKS);
        wr_addr = AW'(in_slot);
        wr_data = '{comp: in_comp_time,
                    period: (in_period_len == 8'd0) ? 8'd1 : in_period_len,
                    deadline: in_due_time, remaining: in_comp_time,
                    slack: in_due_time - in_comp_time, enabled: in_enable_bit};
      end
      S_CALC: wr_en = 1'b1;
      S_FIX: begin
        wr_en   = found_r;
        wr_addr = win_r;
        wr_data = rd_data;
        if (rd_data.remaining != 8'd0) wr_data.remaining = rd_data.remaining - 8'd1;
      end
      S_READ, S_WAIT, S_MOD, S_DONE: ;
      default: ;
    endcase
    if (state_r == S_DONE) rd_addr = win_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      idx_r     <= '0;
      found_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_set) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == (AW+1)'(TASKS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_mode == MODE_LOAD) begin
              out_pick_valid <= 1'b0;
              out_pick_index <= '0;
              out_pick_slack <= '0;
              out_miss_flags <= '0;
            end else begin
              idx_r   <= '0;
              ready_r <= in_ready_mask;
              nowm1_r <= (in_now == 16'd0) ? 16'd0 : in_now - 16'd1;
              miss_r  <= '0;
              best_r  <= SLACK_CEIL;
              win_r   <= '0;
              found_r <= 1'b0;
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          // Skip tasks that are not ready without touching the RAM.
          if (idx_r == (AW+1)'(TASKS)) state_r <= found_r ? S_DONE : S_FIX;
          else if (task_on) state_r <= S_WAIT;
          else idx_r <= idx_r + 1'b1;
        end
        S_WAIT: begin
          ent_r <= rd_data;
          if (rd_data.enabled) state_r <= S_MOD;
          else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_MOD: if (mod_done) state_r <= S_CALC;
        S_CALC: begin
          if (is_miss) miss_r[idx_r[AW-1:0] & 3'(7)] <= 1'b1;
          if (cand) begin
            best_r  <= s_val[7:0];
            win_r   <= idx_r[AW-1:0];
            found_r <= 1'b1;
          end
          idx_r   <= idx_r + 1'b1;
          state_r <= S_READ;
        end
        S_DONE: state_r <= S_FIX;
        S_FIX: begin
          out_pick_valid <= found_r;
          out_pick_index <= found_r ? 3'(win_r) : 3'd0;
          out_pick_slack <= found_r ? best_r : 8'd0;
          out_miss_flags <= miss_r;
          state_r        <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // S_FIX writes only when a winner was found; guard via found_r.
  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> in_stall;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

  a_fix_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX) |=> out_valid) else $error("tick result missing");

  a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (32'(win_r) < TASKS)) else $error("winner out of range");
endmodule

// ===== src/lsts_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module lsts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== src/lsts_mod.sv =====
// Sequential modulo unit: remainder of a 16-bit value by an 8-bit divisor.
module lsts_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [7:0]  rem
);
  logic [15:0] quo_r, quo_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [7:0]  div_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [9:0]  trial;

  // One restoring step per cycle, sixteen steps.
  always_comb begin
    trial   = {rem_r, quo_r[15]} - {2'b00, div_r};
    quo_nxt = {quo_r[14:0], 1'b0};
    if (!trial[9]) rem_nxt = trial[8:0];
    else           rem_nxt = {rem_r[7:0], quo_r[15]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd16;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r[7:0];
endmodule

// ===== sim/least_slack_task_scheduler_unit_test.sv =====
// Self-checking testbench for the least-slack task scheduler unit.
module least_slack_task_scheduler_unit_test;
  import lsts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTASK = TASKS_DEF;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = MODE_LOAD;
  logic [2:0]  in_slot = '0;
  logic [7:0]  in_comp_time = '0;
  logic [7:0]  in_period_len = '0;
  logic [7:0]  in_due_time = '0;
  logic        in_enable_bit = 1'b0;
  logic [7:0]  in_ready_mask = '0;
  logic [15:0] in_now = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_pick_valid;
  logic [2:0]  out_pick_index;
  logic [7:0]  out_pick_slack;
  logic [7:0]  out_miss_flags;

  typedef struct packed {
    logic       pick_valid;
    logic [2:0] pick_index;
    logic [7:0] pick_slack;
    logic [7:0] miss_flags;
  } pick_t;

  // Shadow copy of the task table, updated as items are accepted.
  task_entry_t shadow_tbl [NTASK];
  pick_t       pending_picks[$];

  int  mismatches = 0;
  int  picks_seen = 0;
  int  wins_seen = 0;
  int  misses_seen = 0;
  int  idle_cycles = 0;
  bit  idle_on = 1'b1;    // random gaps on both sides
  bit  hold_off = 1'b0;   // receiver blocks for a long stretch
  bit  test_done = 1'b0;

  least_slack_task_scheduler_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predict the result of one item and advance the shadow table.
  function automatic pick_t schedule_step(logic mode, logic [2:0] slot, logic [7:0] comp,
                                          logic [7:0] per, logic [7:0] due, logic en,
                                          logic [7:0] ready, logic [15:0] now_in);
    pick_t r;
    int    best, rel, s;
    int    win;
    bit    found;
    logic [15:0] t;
    r = '0;
    best = 255;
    win = 0;
    found = 1'b0;
    if (mode == MODE_LOAD) begin
      if (slot < NTASK) begin
        shadow_tbl[slot].comp = comp;
        shadow_tbl[slot].period = (per == 0) ? 8'd1 : per;
        shadow_tbl[slot].deadline = due;
        shadow_tbl[slot].enabled = en;
        shadow_tbl[slot].remaining = comp;
        shadow_tbl[slot].slack = due - comp;
      end
      return r;
    end
    t = (now_in == 0) ? 16'd1 : now_in;
    for (int i = 0; i < NTASK; i++) begin
      if (i >= 8 || !ready[i] || !shadow_tbl[i].enabled) continue;
      rel = (int'(t) - 1) % int'(shadow_tbl[i].period);
      if (rel == 0) begin
        shadow_tbl[i].remaining = shadow_tbl[i].comp;
        shadow_tbl[i].slack = shadow_tbl[i].deadline - shadow_tbl[i].comp;
      end
      if (shadow_tbl[i].remaining == 0 && rel != 0) continue;
      s = int'(shadow_tbl[i].deadline) - int'(shadow_tbl[i].remaining) - rel;
      if (s < 0) begin
        r.miss_flags[i] = 1'b1;
      end else begin
        shadow_tbl[i].slack = s[7:0];
        if (s < best) begin
          best = s;
          win = i;
          found = 1'b1;
        end
      end
    end
    if (found) begin
      if (shadow_tbl[win].remaining != 0) shadow_tbl[win].remaining--;
      r.pick_valid = 1'b1;
      r.pick_index = win[2:0];
      r.pick_slack = best[7:0];
    end
    return r;
  endfunction

  // Offer one item on the falling edge and hold it until taken; valid drops
  // only when the sender idles or the run ends.
  task automatic send_item(logic mode, logic [2:0] slot, logic [7:0] comp, logic [7:0] per,
                           logic [7:0] due, logic en, logic [7:0] ready, logic [15:0] now_in);
    while (idle_on && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_slot <= slot;
    in_comp_time <= comp;
    in_period_len <= per;
    in_due_time <= due;
    in_enable_bit <= en;
    in_ready_mask <= ready;
    in_now <= now_in;
    do @(posedge clk); while (in_stall);
    pending_picks.push_back(schedule_step(mode, slot, comp, per, due, en, ready, now_in));
    @(negedge clk);
  endtask

  task automatic load_task(int slot, int comp, int per, int due, bit en);
    send_item(MODE_LOAD, slot[2:0], comp[7:0], per[7:0], due[7:0], en, '0, '0);
  endtask

  task automatic tick(int ready, int now_in);
    send_item(MODE_TICK, '0, '0, '0, '0, 1'b0, ready[7:0], now_in[15:0]);
  endtask

  task automatic random_item();
    if ($urandom_range(99) < 20)
      load_task($urandom_range(7), $urandom_range(9) == 0 ? $urandom_range(255) :
                $urandom_range(6), $urandom_range(9) == 0 ? $urandom_range(255) :
                $urandom_range(12), $urandom_range(9) == 0 ? $urandom_range(255) :
                $urandom_range(14), $urandom_range(99) < 85);
    else
      tick($urandom_range(255), $urandom_range(9) == 0 ? $urandom_range(65535) :
           $urandom_range(40));
  endtask

  // Receiver: random stalls, plus a long hold when asked.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= idle_on && ($urandom_range(99) < 32);
  end

  // Check each result against the oldest prediction.
  always @(posedge clk) begin
    pick_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_pick_valid, out_pick_index, out_pick_slack, out_miss_flags};
      picks_seen++;
      if (got.pick_valid) wins_seen++;
      if (got.miss_flags != 0) misses_seen++;
      if (pending_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_picks.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected v%0b i%0d s%0d m%h, got v%0b i%0d s%0d m%h",
                     want.pick_valid, want.pick_index, want.pick_slack, want.miss_flags,
                     got.pick_valid, got.pick_index, got.pick_slack, got.miss_flags);
        end
      end
    end
  end

  // Watchdog: abort when nothing moves for too long.
  always @(posedge clk) begin
    if (!test_done) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic test_extremes();
    tick(8'hFF, 0);                    // empty table: no pick
    load_task(0, 0, 0, 0, 1);          // period zero stored as one, comp zero
    load_task(1, 255, 255, 255, 1);
    load_task(2, 3, 10, 5, 1);
    load_task(3, 3, 10, 5, 1);         // tie with slot 2
    load_task(4, 5, 8, 2, 1);          // negative slack
    load_task(5, 1, 4, 255, 1);        // slack starts at 254, below the ceiling
    load_task(6, 2, 6, 9, 0);          // disabled
    load_task(7, 170, 85, 85, 1);
    tick(8'hFF, 0);
    tick(8'hFF, 1);
    tick(8'hAA, 65535);
    tick(8'h55, 2);
    tick(8'h0C, 3);
    tick(8'h0C, 4);
    tick(8'h01, 7);                    // comp zero winner: remaining stays zero
    tick(8'h00, 12);
  endtask

  task automatic test_periodic_runs();
    for (int k = 0; k < NTASK; k++)
      load_task(k, $urandom_range(4), $urandom_range(1, 10), $urandom_range(12), 1);
    for (int t = 1; t <= 40; t++) tick($urandom_range(255), t);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      repeat (8) random_item();
    join
  endtask

  task automatic test_random();
    int now_ctr;
    now_ctr = 1;
    for (int n = 0; n < 1250; n++) begin
      idle_on = !(n >= 400 && n < 550);
      if ($urandom_range(99) < 70) begin
        // Mostly well-ordered time steps with a fresh task now and then.
        if ($urandom_range(9) == 0)
          load_task($urandom_range(7), $urandom_range(6), $urandom_range(1, 12),
                    $urandom_range(14), $urandom_range(99) < 90);
        else tick($urandom_range(255), now_ctr++);
      end else begin
        random_item();
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < NTASK; i++) shadow_tbl[i] = '{8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0};
    test_extremes();
    test_periodic_runs();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    test_done = 1'b1;
    $display("covered %0d results: %0d with a pick, %0d with deadline misses",
             picks_seen, wins_seen, misses_seen);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
